/* rtl/core/wfdc_pkg.sv */
// Shared mode codes, duty levels and register indexes of the wall-follow drive controller.
package wfdc_pkg;

  // Controller mode codes, as reported on the mode output
  localparam logic [2:0] MODE_DECIDE     = 3'd0;
  localparam logic [2:0] MODE_TURN_RIGHT = 3'd1;
  localparam logic [2:0] MODE_TURN_LEFT  = 3'd2;
  localparam logic [2:0] MODE_DEAD_END   = 3'd3;
  localparam logic [2:0] MODE_DRIVE      = 3'd4;
  localparam logic [2:0] MODE_PAUSE      = 3'd5;

  // Motor duty levels
  localparam logic [7:0] DUTY_FULL = 8'd255;
  localparam logic [7:0] DUTY_SLOW = 8'd150;
  localparam logic [7:0] DUTY_OFF  = 8'd0;

  // Configuration register indexes
  localparam logic [7:0] REG_FRONT_CLEAR   = 8'd0;
  localparam logic [7:0] REG_FRONT_RETRY   = 8'd1;
  localparam logic [7:0] REG_SIDE_OPEN     = 8'd2;
  localparam logic [7:0] REG_STOP_DISTANCE = 8'd3;
  localparam logic [7:0] REG_WALL_NEAR     = 8'd4;
  localparam logic [7:0] REG_TURN_GOAL     = 8'd5;
  localparam logic [7:0] REG_DRIVE_POLL    = 8'd6;
  localparam logic [7:0] REG_PAUSE_TICKS   = 8'd7;

endpackage

/* rtl/core/wall_follow_drive_controller_top.sv */
// Top level of the wall-follow drive controller: tick state machine and result register.

// Right-hand wall follower advanced once per accepted tick. Each tick carries the two
// encoder A levels and the front, left and right distances; one result (direction bits,
// duties, mode) comes back per tick and shows the state after that tick. The tick is
// evaluated in the cycle it is accepted and its result appears in the output register on
// the next cycle, so one tick is taken every cycle while no result is stalled; the only
// thing that holds off input is a result still stalled in the output register.
// Configuration registers are written through the cfg port (always ready); the user must
// write them only while the block is idle, a rule the block leaves to the user; indexes above 7 are ignored.
module wall_follow_drive_controller_top
  import wfdc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // Tick input
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        enc_left_i,
  input  logic        enc_right_i,
  input  logic [15:0] front_mm_i,
  input  logic [15:0] left_mm_i,
  input  logic [15:0] right_mm_i,
  // Result output
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        left_reverse_o,
  output logic        right_reverse_o,
  output logic [7:0]  left_duty_o,
  output logic [7:0]  right_duty_o,
  output logic [2:0]  mode_o,
  // Configuration write
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  // Configuration registers
  logic [15:0] front_clear_q, front_retry_q, side_open_q, stop_distance_q, wall_near_q;
  logic [7:0]  turn_goal_q, drive_poll_q, pause_ticks_q;

  // Controller state
  logic [2:0]  mode_q, mode_d;
  logic [15:0] left_count_q, left_count_d;
  logic [15:0] right_count_q, right_count_d;
  logic        left_prev_q, right_prev_q;
  logic [15:0] turn_target_q, turn_target_d;
  logic [7:0]  wait_q, wait_d;
  logic [7:0]  held_left_q, held_left_d;
  logic [7:0]  held_right_q, held_right_d;

  // Result register
  logic        out_valid_q;
  logic        lrev_q, rrev_q, lrev_d, rrev_d;
  logic [7:0]  lduty_q, rduty_q, lduty_d, rduty_d;
  logic [2:0]  mode_out_q;

  logic        in_xfer;
  logic [15:0] left_diff, right_diff;
  logic        left_done, right_done;
  logic [7:0]  wait_inc;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = out_valid_q & out_stall_i;
  assign in_xfer     = in_valid_i & ~in_stall_o;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_clear_q   <= 16'd150;
      front_retry_q   <= 16'd180;
      side_open_q     <= 16'd180;
      stop_distance_q <= 16'd55;
      wall_near_q     <= 16'd150;
      turn_goal_q     <= 8'd14;
      drive_poll_q    <= 8'd6;
      pause_ticks_q   <= 8'd20;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_FRONT_CLEAR:   front_clear_q   <= cfg_data_i;
        REG_FRONT_RETRY:   front_retry_q   <= cfg_data_i;
        REG_SIDE_OPEN:     side_open_q     <= cfg_data_i;
        REG_STOP_DISTANCE: stop_distance_q <= cfg_data_i;
        REG_WALL_NEAR:     wall_near_q     <= cfg_data_i;
        REG_TURN_GOAL:     turn_goal_q     <= cfg_data_i[7:0];
        REG_DRIVE_POLL:    drive_poll_q    <= cfg_data_i[7:0];
        REG_PAUSE_TICKS:   pause_ticks_q   <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // Count rising encoder edges on every tick
  assign left_count_d  = left_count_q + {15'd0, enc_left_i & ~left_prev_q};
  assign right_count_d = right_count_q + {15'd0, enc_right_i & ~right_prev_q};

  // Turn completion: wrapped difference to the target is not negative
  assign left_diff  = left_count_d - turn_target_q;
  assign right_diff = right_count_d - turn_target_q;
  assign left_done  = ~left_diff[15];
  assign right_done = ~right_diff[15];
  assign wait_inc   = wait_q + 8'd1;

  // Advance the state machine for one tick
  always_comb begin
    mode_d        = mode_q;
    turn_target_d = turn_target_q;
    wait_d        = wait_q;
    held_left_d   = held_left_q;
    held_right_d  = held_right_q;
    case (mode_q)
      MODE_TURN_RIGHT, MODE_TURN_LEFT: begin
        if ((mode_q == MODE_TURN_LEFT) ? left_done : right_done) begin
          wait_d = 8'd0;
          if (front_mm_i > stop_distance_q) begin
            mode_d = MODE_DRIVE; held_left_d = DUTY_SLOW; held_right_d = DUTY_SLOW;
          end else begin
            mode_d = MODE_PAUSE; held_left_d = DUTY_OFF; held_right_d = DUTY_OFF;
          end
        end
      end
      MODE_DEAD_END: begin
        if (right_done) begin
          if (front_mm_i <= front_retry_q) begin
            turn_target_d = right_count_d + {8'd0, turn_goal_q};
          end else begin
            wait_d = 8'd0;
            if (front_mm_i > stop_distance_q) begin
              mode_d = MODE_DRIVE; held_left_d = DUTY_SLOW; held_right_d = DUTY_SLOW;
            end else begin
              mode_d = MODE_PAUSE; held_left_d = DUTY_OFF; held_right_d = DUTY_OFF;
            end
          end
        end
      end
      MODE_DRIVE: begin
        wait_d = wait_inc;
        if (wait_inc >= drive_poll_q) begin
          wait_d = 8'd0;
          // Steer away from the nearer wall; hold duties when walls are equal
          if (left_mm_i < wall_near_q && right_mm_i < wall_near_q) begin
            if (left_mm_i < right_mm_i) begin
              held_left_d = DUTY_SLOW; held_right_d = DUTY_FULL;
            end else if (right_mm_i < left_mm_i) begin
              held_left_d = DUTY_FULL; held_right_d = DUTY_SLOW;
            end
          end else begin
            held_left_d = DUTY_FULL; held_right_d = DUTY_FULL;
          end
          if (front_mm_i <= stop_distance_q) begin
            mode_d = MODE_PAUSE; held_left_d = DUTY_OFF; held_right_d = DUTY_OFF;
          end
        end
      end
      MODE_PAUSE: begin
        wait_d = wait_inc;
        if (wait_inc >= pause_ticks_q) begin
          wait_d = 8'd0;
          mode_d = MODE_DECIDE;
        end
      end
      default: begin
        // Decide: straight, right, left, dead-end turn, else drive
        if (front_mm_i > front_clear_q || (right_mm_i <= side_open_q &&
            left_mm_i <= side_open_q && front_mm_i > front_retry_q)) begin
          wait_d = 8'd0;
          if (front_mm_i > stop_distance_q) begin
            mode_d = MODE_DRIVE; held_left_d = DUTY_SLOW; held_right_d = DUTY_SLOW;
          end else begin
            mode_d = MODE_PAUSE; held_left_d = DUTY_OFF; held_right_d = DUTY_OFF;
          end
        end else if (right_mm_i > side_open_q) begin
          mode_d = MODE_TURN_RIGHT;
          turn_target_d = right_count_d + {8'd0, turn_goal_q};
        end else if (left_mm_i > side_open_q) begin
          mode_d = MODE_TURN_LEFT;
          turn_target_d = left_count_d + {8'd0, turn_goal_q};
        end else begin
          mode_d = MODE_DEAD_END;
          turn_target_d = right_count_d + {8'd0, turn_goal_q};
        end
      end
    endcase
  end

  // Drive motors from the new mode
  always_comb begin
    lrev_d  = 1'b0;
    rrev_d  = 1'b0;
    lduty_d = DUTY_OFF;
    rduty_d = DUTY_OFF;
    case (mode_d)
      MODE_TURN_RIGHT, MODE_DEAD_END: begin
        lrev_d = 1'b1; lduty_d = DUTY_FULL; rduty_d = DUTY_FULL;
      end
      MODE_TURN_LEFT: begin
        rrev_d = 1'b1; lduty_d = DUTY_FULL; rduty_d = DUTY_FULL;
      end
      MODE_DRIVE: begin
        lduty_d = held_left_d; rduty_d = held_right_d;
      end
      default: ;
    endcase
  end

  // Update state on each tick transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q        <= MODE_DECIDE;
      left_count_q  <= 16'd0;
      right_count_q <= 16'd0;
      left_prev_q   <= 1'b0;
      right_prev_q  <= 1'b0;
      turn_target_q <= 16'd0;
      wait_q        <= 8'd0;
      held_left_q   <= 8'd0;
      held_right_q  <= 8'd0;
    end else if (in_xfer) begin
      mode_q        <= mode_d;
      left_count_q  <= left_count_d;
      right_count_q <= right_count_d;
      left_prev_q   <= enc_left_i;
      right_prev_q  <= enc_right_i;
      turn_target_q <= turn_target_d;
      wait_q        <= wait_d;
      held_left_q   <= held_left_d;
      held_right_q  <= held_right_d;
    end
  end

  // Hold result valid until its transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_xfer) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Load result payload
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      lrev_q     <= lrev_d;
      rrev_q     <= rrev_d;
      lduty_q    <= lduty_d;
      rduty_q    <= rduty_d;
      mode_out_q <= (mode_d <= MODE_PAUSE) ? mode_d : MODE_DECIDE;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign left_reverse_o  = lrev_q;
  assign right_reverse_o = rrev_q;
  assign left_duty_o     = lduty_q;
  assign right_duty_o    = rduty_q;
  assign mode_o          = mode_out_q;

  // Input is held off only by a stalled result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled without a pending result");

  // Reported mode matches the controller state after the tick
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> (mode_o == mode_q))
    else $error("reported mode differs from controller state");

  // Turning modes spin the wheels at full duty in opposite directions
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (mode_o == MODE_TURN_RIGHT || mode_o == MODE_DEAD_END ||
                     mode_o == MODE_TURN_LEFT))
    |-> (left_duty_o == DUTY_FULL && right_duty_o == DUTY_FULL &&
         (left_reverse_o != right_reverse_o)))
    else $error("turn without full opposed duty");

  // Stopped modes drive nothing
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (mode_o == MODE_PAUSE || mode_o == MODE_DECIDE))
    |-> (left_duty_o == DUTY_OFF && right_duty_o == DUTY_OFF &&
         !left_reverse_o && !right_reverse_o))
    else $error("motors running while stopped");

endmodule

/* sim/wall_follow_drive_controller_top_tb.sv */
// Self-checking testbench for the wall-follow drive controller: tick predictor and scoreboard.
module wall_follow_drive_controller_top_tb
  import wfdc_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT    = 400000;
  localparam logic [7:0]  REG_UNUSED_LOW = 8'd8;
  localparam logic [7:0]  REG_UNUSED_TOP = 8'hFF;

  typedef struct packed {
    logic        enc_l;
    logic        enc_r;
    logic [15:0] front_mm;
    logic [15:0] left_mm;
    logic [15:0] right_mm;
  } tick_t;

  typedef struct packed {
    logic       left_rev;
    logic       right_rev;
    logic [7:0] left_duty;
    logic [7:0] right_duty;
    logic [2:0] mode;
  } drive_cmd_t;

  // Tracks the controller state per tick and holds the motor commands still to come
  class drive_tracker;
    logic [15:0] front_clear, front_retry, side_open, stop_distance, wall_near;
    logic [7:0]  turn_goal, drive_poll, pause_len;
    logic [2:0]  ctrl_mode;
    logic [15:0] left_cnt, right_cnt, turn_target;
    logic        left_lvl, right_lvl;
    logic [7:0]  wait_cnt, hold_left, hold_right;
    drive_cmd_t  pending[$];
    int unsigned errors;

    function new();
      front_clear = 16'd150; front_retry = 16'd180; side_open = 16'd180;
      stop_distance = 16'd55; wall_near = 16'd150;
      turn_goal = 8'd14; drive_poll = 8'd6; pause_len = 8'd20;
      ctrl_mode = MODE_DECIDE;
      left_cnt = '0; right_cnt = '0; turn_target = '0;
      left_lvl = 1'b0; right_lvl = 1'b0;
      wait_cnt = '0; hold_left = DUTY_OFF; hold_right = DUTY_OFF;
      errors = 0;
    endfunction

    function void write_reg(logic [7:0] idx, logic [15:0] data);
      case (idx)
        REG_FRONT_CLEAR:   front_clear = data;
        REG_FRONT_RETRY:   front_retry = data;
        REG_SIDE_OPEN:     side_open = data;
        REG_STOP_DISTANCE: stop_distance = data;
        REG_WALL_NEAR:     wall_near = data;
        REG_TURN_GOAL:     turn_goal = data[7:0];
        REG_DRIVE_POLL:    drive_poll = data[7:0];
        REG_PAUSE_TICKS:   pause_len = data[7:0];
        default: ;
      endcase
    endfunction

    function void begin_turn(logic [2:0] mode);
      ctrl_mode = mode;
      turn_target = ((mode == MODE_TURN_LEFT) ? left_cnt : right_cnt) + 16'(turn_goal);
    endfunction

    // Enter driving, or drop straight to pause when the wall is already close
    function void begin_drive(logic [15:0] front);
      wait_cnt = '0;
      if (front > stop_distance) begin
        ctrl_mode = MODE_DRIVE;
        hold_left = DUTY_SLOW;
        hold_right = DUTY_SLOW;
      end else begin
        ctrl_mode = MODE_PAUSE;
        hold_left = DUTY_OFF;
        hold_right = DUTY_OFF;
      end
    endfunction

    function bit turn_reached(logic [15:0] count);
      logic [15:0] diff;
      diff = count - turn_target;
      return !diff[15];
    endfunction

    function void note_tick(tick_t t);
      drive_cmd_t cmd;
      // Count rising encoder edges on every tick
      if (t.enc_l && !left_lvl) left_cnt = left_cnt + 16'd1;
      if (t.enc_r && !right_lvl) right_cnt = right_cnt + 16'd1;
      left_lvl = t.enc_l;
      right_lvl = t.enc_r;

      case (ctrl_mode)
        MODE_TURN_RIGHT, MODE_TURN_LEFT: begin
          if (turn_reached((ctrl_mode == MODE_TURN_LEFT) ? left_cnt : right_cnt))
            begin_drive(t.front_mm);
        end
        MODE_DEAD_END: begin
          if (turn_reached(right_cnt)) begin
            if (t.front_mm <= front_retry) begin_turn(MODE_DEAD_END);
            else begin_drive(t.front_mm);
          end
        end
        MODE_DRIVE: begin
          wait_cnt = wait_cnt + 8'd1;
          if (wait_cnt >= drive_poll) begin
            wait_cnt = '0;
            // Steer away from the nearer wall; equal walls keep the old duties
            if (t.left_mm < wall_near && t.right_mm < wall_near) begin
              if (t.left_mm < t.right_mm) begin
                hold_left = DUTY_SLOW; hold_right = DUTY_FULL;
              end else if (t.right_mm < t.left_mm) begin
                hold_left = DUTY_FULL; hold_right = DUTY_SLOW;
              end
            end else begin
              hold_left = DUTY_FULL; hold_right = DUTY_FULL;
            end
            if (t.front_mm <= stop_distance) begin
              ctrl_mode = MODE_PAUSE;
              hold_left = DUTY_OFF; hold_right = DUTY_OFF;
            end
          end
        end
        MODE_PAUSE: begin
          wait_cnt = wait_cnt + 8'd1;
          if (wait_cnt >= pause_len) begin
            wait_cnt = '0;
            ctrl_mode = MODE_DECIDE;
          end
        end
        default: begin
          if (t.front_mm > front_clear) begin_drive(t.front_mm);
          else if (t.right_mm > side_open) begin_turn(MODE_TURN_RIGHT);
          else if (t.left_mm > side_open) begin_turn(MODE_TURN_LEFT);
          else if (t.front_mm <= front_retry) begin_turn(MODE_DEAD_END);
          else begin_drive(t.front_mm);
        end
      endcase

      // Form the motor command for the state after this tick
      cmd = '0;
      case (ctrl_mode)
        MODE_TURN_RIGHT, MODE_DEAD_END: begin
          cmd.left_rev = 1'b1; cmd.left_duty = DUTY_FULL; cmd.right_duty = DUTY_FULL;
        end
        MODE_TURN_LEFT: begin
          cmd.right_rev = 1'b1; cmd.left_duty = DUTY_FULL; cmd.right_duty = DUTY_FULL;
        end
        MODE_DRIVE: begin
          cmd.left_duty = hold_left; cmd.right_duty = hold_right;
        end
        default: ;
      endcase
      cmd.mode = (ctrl_mode <= MODE_PAUSE) ? ctrl_mode : MODE_DECIDE;
      pending.push_back(cmd);
    endfunction

    function void compare_field(string name, int unsigned exp_v, int unsigned act_v);
      if (exp_v != act_v) begin
        $display("%0t ns: %s mismatch, expected %0d actual %0d", $time, name, exp_v, act_v);
        errors++;
      end
    endfunction

    function void check_cmd(drive_cmd_t got);
      drive_cmd_t exp_cmd;
      if (pending.size() == 0) begin
        $display("%0t ns: unexpected result, expected none actual mode %0d", $time, got.mode);
        errors++;
        return;
      end
      exp_cmd = pending.pop_front();
      compare_field("left_reverse", 32'(exp_cmd.left_rev), 32'(got.left_rev));
      compare_field("right_reverse", 32'(exp_cmd.right_rev), 32'(got.right_rev));
      compare_field("left_duty", 32'(exp_cmd.left_duty), 32'(got.left_duty));
      compare_field("right_duty", 32'(exp_cmd.right_duty), 32'(got.right_duty));
      compare_field("mode", 32'(exp_cmd.mode), 32'(got.mode));
    endfunction
  endclass

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        enc_l = 1'b0;
  logic        enc_r = 1'b0;
  logic [15:0] front_mm = '0;
  logic [15:0] left_mm = '0;
  logic [15:0] right_mm = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        left_rev, right_rev;
  logic [7:0]  left_duty, right_duty;
  logic [2:0]  mode;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [7:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  int unsigned   sender_idle_pct = 0;
  int unsigned   receiver_stall_pct = 0;
  int unsigned   cycles = 0;
  drive_tracker  sb;

  wall_follow_drive_controller_top dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .enc_left_i     (enc_l),
    .enc_right_i    (enc_r),
    .front_mm_i     (front_mm),
    .left_mm_i      (left_mm),
    .right_mm_i     (right_mm),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .left_reverse_o (left_rev),
    .right_reverse_o(right_rev),
    .left_duty_o    (left_duty),
    .right_duty_o   (right_duty),
    .mode_o         (mode),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Observe register writes, tick transfers and result transfers
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_data);
      if (in_valid && !in_stall) sb.note_tick({enc_l, enc_r, front_mm, left_mm, right_mm});
      if (out_valid && !out_stall) sb.check_cmd({left_rev, right_rev, left_duty, right_duty, mode});
    end
  end

  // Stall the result side at random
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < receiver_stall_pct);
  end

  task automatic send_tick(input tick_t t);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    {enc_l, enc_r, front_mm, left_mm, right_mm} <= t;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic put_reg(input logic [7:0] idx, input logic [15:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic apply_config(input logic [15:0] fc, fr, so, sd, wn, tg, dp, pt);
    put_reg(REG_FRONT_CLEAR, fc);
    put_reg(REG_FRONT_RETRY, fr);
    put_reg(REG_SIDE_OPEN, so);
    put_reg(REG_STOP_DISTANCE, sd);
    put_reg(REG_WALL_NEAR, wn);
    put_reg(REG_TURN_GOAL, tg);
    put_reg(REG_DRIVE_POLL, dp);
    put_reg(REG_PAUSE_TICKS, pt);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // Hold off ticks until every result has arrived, then let the pipeline settle
  task automatic drain_results();
    in_valid <= 1'b0;
    @(negedge clk);
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  function automatic logic [15:0] rand_level();
    if ($urandom_range(99) < 80) return 16'($urandom_range(0, 400));
    return 16'($urandom_range(0, 65535));
  endfunction

  task automatic rand_config();
    logic [7:0] hi_a, hi_b, hi_c;
    hi_a = 8'($urandom_range(0, 255));
    hi_b = 8'($urandom_range(0, 255));
    hi_c = 8'($urandom_range(0, 255));
    apply_config(rand_level(), rand_level(), rand_level(), rand_level(), rand_level(),
                 {hi_a, 8'($urandom_range(0, 20))}, {hi_b, 8'($urandom_range(0, 12))},
                 {hi_c, 8'($urandom_range(0, 30))});
  endtask

  // Favor distances right at the thresholds now in use
  function automatic logic [15:0] pick_dist();
    int sel;
    int thr;
    int val;
    sel = $urandom_range(99);
    if (sel < 30) begin
      case ($urandom_range(0, 4))
        0: thr = int'(sb.front_clear);
        1: thr = int'(sb.front_retry);
        2: thr = int'(sb.side_open);
        3: thr = int'(sb.stop_distance);
        default: thr = int'(sb.wall_near);
      endcase
      val = thr + $urandom_range(0, 4) - 2;
      if (val < 0) val = 0;
      if (val > 65535) val = 65535;
      return 16'(val);
    end
    if (sel < 70) return 16'($urandom_range(0, 400));
    if (sel < 80) return ($urandom_range(1) != 0) ? 16'hFFFF : 16'h0000;
    return 16'($urandom_range(0, 65535));
  endfunction

  // Send segments of steady distances with turning encoders, some segments noisy
  task automatic run_ticks(input int n, input int pressure_at);
    int seg_left;
    bit noisy;
    logic [15:0] base_f, base_l, base_r;
    tick_t t;
    seg_left = 0;
    noisy = 1'b0;
    base_f = '0; base_l = '0; base_r = '0;
    t = '0;
    for (int i = 0; i < n; i++) begin
      if (seg_left == 0) begin
        seg_left = $urandom_range(1, 30);
        noisy = ($urandom_range(99) < 10);
        base_f = pick_dist();
        base_l = pick_dist();
        base_r = pick_dist();
      end
      seg_left--;
      if (noisy) begin
        t.enc_l = 1'($urandom_range(1));
        t.enc_r = 1'($urandom_range(1));
      end else begin
        t.enc_l = ($urandom_range(99) < 75) ? !t.enc_l : 1'($urandom_range(1));
        t.enc_r = ($urandom_range(99) < 75) ? !t.enc_r : 1'($urandom_range(1));
      end
      t.front_mm = ($urandom_range(99) < 80) ? base_f : pick_dist();
      t.left_mm = ($urandom_range(99) < 80) ? base_l : pick_dist();
      t.right_mm = ($urandom_range(99) < 80) ? base_r : pick_dist();
      send_tick(t);
      if (i == pressure_at) drain_results();
    end
  endtask

  task automatic set_idling(input int unsigned snd, input int unsigned rcv);
    sender_idle_pct = snd;
    receiver_stall_pct = rcv;
  endtask

  initial begin
    sb = new();
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: one-tick turns and polls, no pause, retry below clear
    apply_config(16'd150, 16'd100, 16'd180, 16'd55, 16'd150, 16'd1, 16'd1, 16'd0);
    send_tick({1'b0, 1'b0, 16'hFFFF, 16'd0, 16'd0});      // clear front: drive
    send_tick({1'b0, 1'b0, 16'd1000, 16'd10, 16'd20});    // left wall nearer
    send_tick({1'b0, 1'b0, 16'd1000, 16'd20, 16'd10});    // right wall nearer
    send_tick({1'b0, 1'b0, 16'd1000, 16'd30, 16'd30});    // equal walls: hold
    send_tick({1'b0, 1'b0, 16'd1000, 16'd200, 16'd10});   // one side far: full
    send_tick({1'b0, 1'b0, 16'd55, 16'd0, 16'd0});        // at stop distance
    send_tick({1'b0, 1'b0, 16'd0, 16'd0, 16'd0});         // one-tick pause
    send_tick({1'b0, 1'b0, 16'd0, 16'd0, 16'd181});       // right open
    send_tick({1'b0, 1'b1, 16'd0, 16'd0, 16'd0});         // turn done, front close
    send_tick({1'b0, 1'b1, 16'd0, 16'd0, 16'd0});
    send_tick({1'b0, 1'b1, 16'd100, 16'hFFFF, 16'd0});    // left open
    send_tick({1'b1, 1'b1, 16'd200, 16'd0, 16'd0});       // left turn done
    send_tick({1'b1, 1'b1, 16'd0, 16'd0, 16'd0});
    send_tick({1'b1, 1'b1, 16'd0, 16'd0, 16'd0});
    send_tick({1'b1, 1'b0, 16'd120, 16'd0, 16'd0});       // between retry and clear
    send_tick({1'b0, 1'b0, 16'd0, 16'd0, 16'd0});
    send_tick({1'b0, 1'b0, 16'd0, 16'd0, 16'd0});
    send_tick({1'b0, 1'b0, 16'd50, 16'd0, 16'd0});        // dead end
    send_tick({1'b0, 1'b1, 16'd50, 16'd0, 16'd0});        // still blocked: repeat
    send_tick({1'b0, 1'b0, 16'd50, 16'd0, 16'd0});
    send_tick({1'b0, 1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF});
    send_tick({1'b0, 1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF});

    // Random phases over several settings and idling patterns
    drain_results();
    apply_config(16'd150, 16'd180, 16'd180, 16'd55, 16'd150, 16'd14, 16'd6, 16'd20);
    set_idling(0, 0);
    run_ticks(220, -1);

    drain_results();
    apply_config(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
    set_idling(64, 0);
    run_ticks(220, -1);

    drain_results();
    apply_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                 16'hFFFF, 16'hFFFF, 16'hFFFF);
    set_idling(0, 64);
    run_ticks(150, -1);

    drain_results();
    rand_config();
    set_idling(24, 24);
    run_ticks(220, 110);

    // Upper data bits of byte registers and unused indexes must be ignored
    drain_results();
    apply_config(16'h5A96, 16'h7F20, 16'hC0B4, 16'h0837, 16'h0196, 16'hAB05, 16'hFF03, 16'h8004);
    put_reg(REG_UNUSED_LOW, 16'hFFFF);
    put_reg(REG_UNUSED_TOP, 16'h0000);
    cfg_valid <= 1'b0;
    @(negedge clk);
    set_idling(0, 0);
    run_ticks(220, -1);

    drain_results();
    rand_config();
    set_idling(64, 0);
    run_ticks(210, -1);

    drain_results();
    rand_config();
    set_idling(0, 64);
    run_ticks(210, -1);

    drain_results();
    rand_config();
    set_idling(24, 24);
    run_ticks(210, -1);

    // Wait out the last results
    drain_results();
    repeat (4) @(posedge clk);
    if (sb.errors == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule

/* sim.f */
rtl/core/wfdc_pkg.sv
rtl/core/wall_follow_drive_controller_top.sv
sim/wall_follow_drive_controller_top_tb.sv
